// ===== hw/rtl/bpl_pkg.sv =====
package bpl_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatW   = 2;
  localparam int unsigned FidxW   = 5;
  localparam int unsigned LenW    = 6;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutW    = 16;

  typedef enum logic [2:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_AT    = 3'd1,
    REQ_INS_END   = 3'd2,
    REQ_DEL_FRONT = 3'd3,
    REQ_DEL_AT    = 3'd4,
    REQ_DEL_END   = 3'd5,
    REQ_SEARCH    = 3'd6
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_LOAD = 2'd1,
    SEL_PREV = 2'd2,
    SEL_NEXT = 2'd3
  } cell_sel_e;

  typedef struct packed {
    cell_sel_e sel;
    logic      cmp_en;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/bpl_cell.sv =====
module bpl_cell (
  input  logic                          clk_i,
  input  bpl_pkg::cell_ctrl_t           ctrl_i,
  input  logic [bpl_pkg::DataW-1:0]     load_i,
  input  logic [bpl_pkg::DataW-1:0]     prev_i,
  input  logic [bpl_pkg::DataW-1:0]     next_i,
  input  logic [bpl_pkg::DataW-1:0]     key_i,
  output logic [bpl_pkg::DataW-1:0]     value_o,
  output logic                          match_o
);

  logic [bpl_pkg::DataW-1:0] value_q;
  logic                      match_q;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.sel)
      bpl_pkg::SEL_LOAD: value_q <= load_i;
      bpl_pkg::SEL_PREV: value_q <= prev_i;
      bpl_pkg::SEL_NEXT: value_q <= next_i;
      default:           value_q <= value_q;
    endcase
    if (ctrl_i.cmp_en) begin
      match_q <= (value_q == key_i);
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ===== hw/rtl/bpl_find.sv =====
module bpl_find #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic [CAPACITY-1:0]          match_i,
  input  logic [CAPACITY-1:0]          valid_i,
  output logic                         found_o,
  output logic [bpl_pkg::FidxW-1:0]    fidx_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned XW   = (IdxW > bpl_pkg::FidxW) ? IdxW : bpl_pkg::FidxW;

  logic [XW-1:0] idx;
  logic          hit;

  // lowest matching cell wins
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match_i[i] && valid_i[i]) begin
        hit = 1'b1;
        idx = XW'(i);
      end
    end
  end

  assign found_o = hit;
  assign fidx_o  = idx[bpl_pkg::FidxW-1:0];

endmodule

// ===== hw/rtl/bounded_positional_list.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: req_type; tdata: item_value, position
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status, found, found_index, list_length
//
// For each word, the cell row shifts and compares at the accept edge, then the
// first-match encoder and status load the output register once it is free.
// tready drops while a word waits for that load; the output register lets
// the next word be accepted while a result waits on m_axis.
// Reset empties the list at once; cell contents are not cleared.
module bounded_positional_list #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value[31:0], position[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,   // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[1:0], found[2], found_index[7:3],
                                      // list_length[13:8], zero pad
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW > bpl_pkg::PosW) ? CW : bpl_pkg::PosW;

  logic                          busy_q;
  logic                          srch_q, srch_d;
  bpl_pkg::status_e              st_q, st_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic                          out_valid_q;
  logic [bpl_pkg::OutW-1:0]      out_q;

  logic                          s_fire, m_fire, load_out;
  logic [bpl_pkg::DataW-1:0]     item_value;
  logic [bpl_pkg::PosW-1:0]      position;
  bpl_pkg::req_e                 req;
  logic [EW-1:0]                 ep, cnt_ext, pos_ext;
  logic                          is_ins, is_del, op_ok;

  logic [bpl_pkg::DataW-1:0]     val_w [CAPACITY];
  logic [CAPACITY-1:0]           match_w, valid_w;
  bpl_pkg::cell_ctrl_t           ctrl_w [CAPACITY];
  logic                          found_w;
  logic [bpl_pkg::FidxW-1:0]     fidx_w;

  assign s_axis_tready = !busy_q;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = out_valid_q && m_axis_tready;
  assign load_out      = busy_q && (!out_valid_q || m_axis_tready);

  assign item_value = s_axis_tdata[31:0];
  assign position   = s_axis_tdata[37:32];
  assign req        = bpl_pkg::req_e'(s_axis_tuser);
  assign cnt_ext    = EW'(cnt_q);
  assign pos_ext    = EW'(position);

  always_comb begin
    is_ins = 1'b0;
    is_del = 1'b0;
    srch_d = 1'b0;
    ep     = '0;
    case (req)
      bpl_pkg::REQ_INS_FRONT: is_ins = 1'b1;
      bpl_pkg::REQ_INS_AT: begin
        is_ins = 1'b1;
        ep     = pos_ext;
      end
      bpl_pkg::REQ_INS_END: begin
        is_ins = 1'b1;
        ep     = cnt_ext;
      end
      bpl_pkg::REQ_DEL_FRONT: is_del = 1'b1;
      bpl_pkg::REQ_DEL_AT: begin
        is_del = 1'b1;
        ep     = pos_ext;
      end
      bpl_pkg::REQ_DEL_END: begin
        is_del = 1'b1;
        ep     = cnt_ext - EW'(1);
      end
      bpl_pkg::REQ_SEARCH: srch_d = 1'b1;
      default: ;
    endcase

    st_d = bpl_pkg::ST_OK;
    if (is_ins) begin
      if (ep > cnt_ext) begin
        st_d = bpl_pkg::ST_BOUNDS;
      end else if (cnt_q == CW'(CAPACITY)) begin
        st_d = bpl_pkg::ST_FULL;
      end
    end else if (is_del) begin
      if (cnt_q == '0) begin
        st_d = bpl_pkg::ST_EMPTY;
      end else if (ep >= cnt_ext) begin
        st_d = bpl_pkg::ST_BOUNDS;
      end
    end
    op_ok = (st_d == bpl_pkg::ST_OK);

    cnt_d = cnt_q;
    if (s_fire && op_ok && is_ins) begin
      cnt_d = cnt_q + CW'(1);
    end else if (s_fire && op_ok && is_del) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [bpl_pkg::DataW-1:0] prev_v, next_v;

    if (g == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = val_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_n
      assign next_v = val_w[g+1];
    end

    always_comb begin
      ctrl_w[g].sel    = bpl_pkg::SEL_HOLD;
      ctrl_w[g].cmp_en = s_fire && srch_d;
      if (s_fire && op_ok && is_ins) begin
        if (EW'(g) == ep) begin
          ctrl_w[g].sel = bpl_pkg::SEL_LOAD;
        end else if (EW'(g) > ep) begin
          ctrl_w[g].sel = bpl_pkg::SEL_PREV;
        end
      end else if (s_fire && op_ok && is_del) begin
        if (EW'(g) >= ep) begin
          ctrl_w[g].sel = bpl_pkg::SEL_NEXT;
        end
      end
    end

    assign valid_w[g] = (EW'(g) < cnt_ext);

    bpl_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_w[g]),
      .load_i  (item_value),
      .prev_i  (prev_v),
      .next_i  (next_v),
      .key_i   (item_value),
      .value_o (val_w[g]),
      .match_o (match_w[g])
    );
  end

  bpl_find #(
    .CAPACITY (CAPACITY)
  ) u_find (
    .match_i (match_w),
    .valid_i (valid_w),
    .found_o (found_w),
    .fidx_o  (fidx_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (s_fire) begin
        busy_q <= 1'b1;
      end else if (load_out) begin
        busy_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      st_q   <= st_d;
      srch_q <= srch_d;
    end
    if (load_out) begin
      out_q <= {2'b00,
                cnt_ext[bpl_pkg::LenW-1:0],
                srch_q ? fidx_w : bpl_pkg::FidxW'(0),
                srch_q && found_w,
                st_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("list count above capacity");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && is_ins && op_ok) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow the list");

  a_del_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && is_del && op_ok) |=> (cnt_q == $past(cnt_q) - CW'(1)))
    else $error("delete did not shrink the list");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q[2]) |-> (out_q[1:0] == bpl_pkg::ST_OK))
    else $error("hit reported with bad status");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q[1:0] == bpl_pkg::ST_EMPTY) |-> (out_q[13:8] == '0))
    else $error("empty status with nonzero length");

endmodule
